// ----- sv/fsgs_pkg.sv -----
// fsgs_pkg: shared types and constants for the sand grid step unit
// used by falling_sand_grid_step_unit; depends on nothing
`default_nettype none

package fsgs_pkg;

    // command codes
    localparam logic [1:0] OP_PLACE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_PASS  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // diagonal choice lfsr, galois form, right shifting
    localparam logic [15:0] LFSR_TAPS     = 16'hB400;
    localparam logic [15:0] LFSR_FALLBACK = 16'hACE1;
    localparam logic [15:0] SEED_RESET    = 16'd44257;

    localparam logic [10:0] MOVED_MAX = 11'd2047;

    // columns resolved per clock during a pass
    localparam int COLS_PER_STEP = 8;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] row;
        logic [4:0] col;
    } t_cmd;

    typedef struct packed {
        logic        occupied;
        logic [10:0] moved_grains;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/falling_sand_grid_step_unit.sv -----
// falling_sand_grid_step_unit: sand grain occupancy grid with an in-place gravity pass
// depends on fsgs_pkg (command and result words, command codes, lfsr constants)
`default_nettype none

// The block holds a GRID_SIDE x GRID_SIDE grid of sand grains, one memory row per grid
// row. A command word is taken when start is high and busy is low; exactly one result
// word follows, shown for one cycle with o_valid high. The receiver cannot stall, so
// o_valid must be sampled every cycle. Place and read pass through one more state
// (S_PLACE or S_ANS) after the memory read; an out-of-grid place or read and a clear
// are answered from idle (clear drops the per-row valid bits). A gravity pass walks
// row pairs bottom to top through the row memory (one read and one write port): per row
// it reads the upper row (S_LOAD_UP), then resolves 8 columns a cycle right to left
// (S_COLS). The seed channel is ready only while the block is idle; writing 0 loads the
// lfsr with 16'hACE1.

module falling_sand_grid_step_unit #(
    parameter int GRID_SIDE = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire fsgs_pkg::t_cmd  i_cmd,
    output logic                 o_valid,
    output fsgs_pkg::t_result    o_result,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [15:0]           i_cfg_data
);

    localparam int AW  = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1;
    localparam int EW  = (AW > 5) ? AW : 5;
    localparam int CPS = fsgs_pkg::COLS_PER_STEP;

    // state codes
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PLACE   = 3'd1;
    localparam logic [2:0] S_ANS     = 3'd2;
    localparam logic [2:0] S_LOAD_LO = 3'd3;
    localparam logic [2:0] S_LOAD_UP = 3'd4;
    localparam logic [2:0] S_COLS    = 3'd5;
    localparam logic [2:0] S_WB0     = 3'd6;
    localparam logic [2:0] S_LOOK    = 3'd7;

    // row memory with per-row valid bits (an invalid row reads as empty)
    logic [GRID_SIDE-1:0] mem [GRID_SIDE];
    logic [GRID_SIDE-1:0] r_valid;
    logic [GRID_SIDE-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic [GRID_SIDE-1:0] rd_row;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [GRID_SIDE-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic                 clr_all;

    // control and working registers
    logic [2:0]           r_state,    n_state;
    logic [AW-1:0]        r_row,      n_row;      // upper row of the pair in work
    logic [AW-1:0]        r_col,      n_col;      // rightmost column of this step
    logic [AW-1:0]        r_row_addr, n_row_addr;
    logic [AW-1:0]        r_col_addr, n_col_addr;
    logic                 r_in_grid,  n_in_grid;
    logic [GRID_SIDE-1:0] r_up,       n_up;
    logic [GRID_SIDE-1:0] r_lo,       n_lo;
    logic [15:0]          r_lfsr,     n_lfsr;
    logic [10:0]          r_cnt,      n_cnt;
    logic                 r_out_valid, n_out_valid;
    fsgs_pkg::t_result    r_out,      n_out;

    // column step results
    logic [GRID_SIDE-1:0] step_up;
    logic [GRID_SIDE-1:0] step_lo;
    logic [15:0]          step_lfsr;
    logic [10:0]          step_cnt;
    logic                 step_last;

    // command address decode
    logic [EW-1:0]        cmd_row_ext;
    logic [EW-1:0]        cmd_col_ext;
    logic                 cmd_in_grid;

    assign cmd_row_ext = EW'(i_cmd.row);
    assign cmd_col_ext = EW'(i_cmd.col);
    assign cmd_in_grid = (int'(i_cmd.row) < GRID_SIDE) && (int'(i_cmd.col) < GRID_SIDE);

    assign rd_row = r_rd_vld ? r_rd_data : '0;

    //--------------------------------------------------------------------------
    // memory: one write and one read port, registered read data
    //--------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
            r_rd_vld  <= r_valid[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (clr_all) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[mem_waddr] <= 1'b1;
        end
    end

    //--------------------------------------------------------------------------
    // column step: up to CPS columns of the current row pair, right to left
    // the lower row is padded with an occupied cell on each side
    //--------------------------------------------------------------------------
    always_comb begin
        logic [GRID_SIDE+1:0] pad;
        logic                 lft;
        logic                 rgt;
        logic                 mv;
        logic                 bit_b;
        int                   c;
        int                   didx;
        pad       = {1'b1, r_lo, 1'b1};
        step_up   = r_up;
        step_lfsr = r_lfsr;
        step_cnt  = r_cnt;
        for (int k = 0; k < CPS; k++) begin
            c     = int'(r_col) - k;
            mv    = 1'b0;
            didx  = 0;
            lft   = 1'b1;
            rgt   = 1'b1;
            bit_b = 1'b0;
            if (c >= 0) begin
                if (step_up[c]) begin
                    lft = pad[c];
                    rgt = pad[c+2];
                    if (!pad[c+1]) begin
                        mv   = 1'b1;
                        didx = c + 1;
                    end else if (!lft && !rgt) begin
                        bit_b     = step_lfsr[0];
                        step_lfsr = {1'b0, step_lfsr[15:1]}
                                  ^ (bit_b ? fsgs_pkg::LFSR_TAPS : 16'h0000);
                        mv        = 1'b1;
                        didx      = bit_b ? c + 2 : c;
                    end else if (!lft) begin
                        mv   = 1'b1;
                        didx = c;
                    end else if (!rgt) begin
                        mv   = 1'b1;
                        didx = c + 2;
                    end
                    if (mv) begin
                        step_up[c] = 1'b0;
                        pad[didx]  = 1'b1;
                        if (step_cnt != fsgs_pkg::MOVED_MAX) begin
                            step_cnt = step_cnt + 11'd1;
                        end
                    end
                end
            end
        end
        step_lo   = pad[GRID_SIDE:1];
        step_last = int'(r_col) < CPS;
    end

    //--------------------------------------------------------------------------
    // sequencer
    //--------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_row_addr  = r_row_addr;
        n_col_addr  = r_col_addr;
        n_in_grid   = r_in_grid;
        n_up        = r_up;
        n_lo        = r_lo;
        n_lfsr      = r_lfsr;
        n_cnt       = r_cnt;
        n_out_valid = 1'b0;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_row_addr;
        mem_wdata   = rd_row;
        mem_re      = 1'b0;
        mem_raddr   = r_row_addr;
        clr_all     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_lfsr = (i_cfg_data != 16'h0000) ? i_cfg_data : fsgs_pkg::LFSR_FALLBACK;
                end
                if (start) begin
                    n_row_addr = cmd_row_ext[AW-1:0];
                    n_col_addr = cmd_col_ext[AW-1:0];
                    n_in_grid  = cmd_in_grid;
                    n_cnt      = '0;
                    n_out      = '0;
                    unique case (i_cmd.operation) inside
                        fsgs_pkg::OP_PLACE, fsgs_pkg::OP_READ: begin
                            if (cmd_in_grid) begin
                                mem_re    = 1'b1;
                                mem_raddr = cmd_row_ext[AW-1:0];
                                n_state   = (i_cmd.operation == fsgs_pkg::OP_PLACE)
                                          ? S_PLACE : S_ANS;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        fsgs_pkg::OP_CLEAR: begin
                            clr_all     = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        fsgs_pkg::OP_PASS: begin
                            // gravity pass: fetch the bottom row first
                            mem_re    = 1'b1;
                            mem_raddr = AW'(GRID_SIDE - 1);
                            n_row     = AW'(GRID_SIDE - 2);
                            n_state   = S_LOAD_LO;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PLACE: begin
                mem_we                 = 1'b1;
                mem_waddr              = r_row_addr;
                mem_wdata              = rd_row;
                mem_wdata[r_col_addr]  = 1'b1;
                n_out.occupied         = 1'b1;
                n_out.moved_grains     = '0;
                n_out_valid            = 1'b1;
                n_state                = S_IDLE;
            end
            S_ANS: begin
                n_out.occupied     = rd_row[r_col_addr];
                n_out.moved_grains = r_cnt;
                n_out_valid        = 1'b1;
                n_state            = S_IDLE;
            end
            S_LOAD_LO: begin
                n_lo      = rd_row;
                mem_re    = 1'b1;
                mem_raddr = r_row;
                n_state   = S_LOAD_UP;
            end
            S_LOAD_UP: begin
                n_up    = rd_row;
                n_col   = AW'(GRID_SIDE - 1);
                n_state = S_COLS;
            end
            S_COLS: begin
                n_up   = step_up;
                n_lo   = step_lo;
                n_lfsr = step_lfsr;
                n_cnt  = step_cnt;
                if (step_last) begin
                    // lower row is final; the upper row becomes the next lower row
                    mem_we    = 1'b1;
                    mem_waddr = r_row + AW'(1);
                    mem_wdata = step_lo;
                    n_lo      = step_up;
                    if (r_row == '0) begin
                        n_state = S_WB0;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_row - AW'(1);
                        n_row     = r_row - AW'(1);
                        n_state   = S_LOAD_UP;
                    end
                end else begin
                    n_col = r_col - AW'(CPS);
                end
            end
            S_WB0: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_lo;
                if (r_in_grid) begin
                    n_state = S_LOOK;
                end else begin
                    n_out.occupied     = 1'b0;
                    n_out.moved_grains = r_cnt;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_LOOK: begin
                mem_re    = 1'b1;
                mem_raddr = r_row_addr;
                n_state   = S_ANS;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lfsr      <= fsgs_pkg::SEED_RESET;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_lfsr      <= n_lfsr;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_row_addr <= n_row_addr;
        r_col_addr <= n_col_addr;
        r_in_grid  <= n_in_grid;
        r_up       <= n_up;
        r_lo       <= n_lo;
        r_out      <= n_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    //--------------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------------
    a_cmd_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted command neither started nor answered");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state != S_IDLE)
        else $error("memory written while idle");

    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("read and write of the same row in one cycle");

    a_moved_from_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.moved_grains != '0
            |-> $past(r_state) == S_ANS || $past(r_state) == S_WB0)
        else $error("moved count reported outside a pass");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COLS |-> int'(r_col) < GRID_SIDE)
        else $error("column index outside the grid");

endmodule

`default_nettype wire

// ----- dv/tb_falling_sand_grid_step_unit.sv -----
// tb_falling_sand_grid_step_unit: self-checking bench for the sand grid step unit
// depends on fsgs_pkg and falling_sand_grid_step_unit; keeps its own grid and lfsr copy
`timescale 1ns / 1ps

module tb_falling_sand_grid_step_unit;

    localparam int GRID_SIDE      = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int CALM_FIRST     = 700;    // words sent without sender gaps
    localparam int CALM_LAST      = 1000;

    // jobs for the driver: a command word, a seed write, or a pause until all results are in
    typedef enum logic [1:0] {
        JOB_CMD,
        JOB_SEED,
        JOB_SETTLE
    } t_job_kind;

    typedef struct packed {
        t_job_kind      kind;
        fsgs_pkg::t_cmd cmd;
        logic [15:0]    seed;
    } t_grid_job;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    fsgs_pkg::t_cmd    i_cmd       = '0;
    logic              o_valid;
    fsgs_pkg::t_result o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [15:0]       i_cfg_data  = '0;

    // own copy of the block state
    logic [GRID_SIDE-1:0] sand_grid [GRID_SIDE];
    logic [15:0]          choice_lfsr;

    t_grid_job         grid_jobs[$];
    fsgs_pkg::t_result predicted_results[$];

    int unsigned cmds_queued  = 0;
    int unsigned words_sent   = 0;
    int unsigned words_seen   = 0;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;

    falling_sand_grid_step_unit #(
        .GRID_SIDE(GRID_SIDE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------------------

    // cells past the side edges (and below the grid) read as full, so nothing walks off
    function automatic logic grain_at(input int r, input int c);
        if (r < 0 || r >= GRID_SIDE || c < 0 || c >= GRID_SIDE) begin
            return 1'b1;
        end
        return sand_grid[r][c];
    endfunction

    // galois lfsr, right shifting; it only steps when a grain has both diagonals free
    function automatic logic next_choice_bit();
        logic b;
        b = choice_lfsr[0];
        choice_lfsr = choice_lfsr >> 1;
        if (b) begin
            choice_lfsr = choice_lfsr ^ fsgs_pkg::LFSR_TAPS;
        end
        return b;
    endfunction

    function automatic void load_seed(input logic [15:0] seed);
        // a zero seed would lock the lfsr up, so the fallback value goes in instead
        choice_lfsr = (seed != 16'd0) ? seed : fsgs_pkg::LFSR_FALLBACK;
    endfunction

    // one gravity pass in place: rows bottom to top, columns right to left
    function automatic int unsigned run_gravity_pass();
        int unsigned moved;
        int          dest;
        logic        left_full;
        logic        right_full;
        logic        go;
        moved = 0;
        for (int r = GRID_SIDE - 2; r >= 0; r--) begin
            for (int c = GRID_SIDE - 1; c >= 0; c--) begin
                if (grain_at(r, c)) begin
                    go   = 1'b1;
                    dest = c;
                    if (grain_at(r + 1, c)) begin
                        left_full  = grain_at(r + 1, c - 1);
                        right_full = grain_at(r + 1, c + 1);
                        if (!left_full && !right_full) begin
                            dest = next_choice_bit() ? c + 1 : c - 1;
                        end else if (!left_full) begin
                            dest = c - 1;
                        end else if (!right_full) begin
                            dest = c + 1;
                        end else begin
                            go = 1'b0;
                        end
                    end
                    if (go) begin
                        sand_grid[r][c]        = 1'b0;
                        sand_grid[r + 1][dest] = 1'b1;
                        if (moved < fsgs_pkg::MOVED_MAX) begin
                            moved++;
                        end
                    end
                end
            end
        end
        return moved;
    endfunction

    function automatic fsgs_pkg::t_result predict_sand_step(input fsgs_pkg::t_cmd cmd);
        fsgs_pkg::t_result res;
        int unsigned       moved;
        moved = 0;
        case (cmd.operation)
            fsgs_pkg::OP_PLACE: begin
                if (cmd.row < GRID_SIDE && cmd.col < GRID_SIDE) begin
                    sand_grid[cmd.row][cmd.col] = 1'b1;
                end
            end
            fsgs_pkg::OP_PASS: begin
                moved = run_gravity_pass();
            end
            fsgs_pkg::OP_CLEAR: begin
                // the lfsr keeps its value across a clear
                foreach (sand_grid[r]) sand_grid[r] = '0;
            end
            default: ;
        endcase
        res.occupied     = (cmd.row < GRID_SIDE && cmd.col < GRID_SIDE) ?
                           grain_at(int'(cmd.row), int'(cmd.col)) : 1'b0;
        res.moved_grains = 11'(moved);
        return res;
    endfunction

    // ---------------------------------------------------------------------------------
    // job list helpers
    // ---------------------------------------------------------------------------------

    task automatic queue_cmd(input logic [1:0] op, input logic [4:0] r, input logic [4:0] c);
        t_grid_job job;
        job           = '0;
        job.kind      = JOB_CMD;
        job.cmd.operation = op;
        job.cmd.row   = r;
        job.cmd.col   = c;
        grid_jobs     = {grid_jobs, job};
        cmds_queued++;
    endtask

    task automatic queue_seed(input logic [15:0] seed);
        t_grid_job job;
        job       = '0;
        job.kind  = JOB_SEED;
        job.seed  = seed;
        grid_jobs = {grid_jobs, job};
    endtask

    task automatic queue_settle();
        t_grid_job job;
        job       = '0;
        job.kind  = JOB_SETTLE;
        grid_jobs = {grid_jobs, job};
    endtask

    // random phase: grains dropped mostly near the top and into a narrow column band,
    // so piles build up on the floor and the diagonal rules and lfsr get a real workout
    task automatic queue_random(input int n);
        int         pick;
        int         band;
        logic [1:0] op;
        logic [4:0] r;
        logic [4:0] c;
        band = $urandom_range(0, GRID_SIDE - 4);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            r    = 5'($urandom);
            c    = 5'($urandom);
            if (pick < 45) begin
                op = fsgs_pkg::OP_PLACE;
                if ($urandom_range(1) != 0) r = 5'($urandom_range(0, 3));
                if ($urandom_range(2) != 0) c = 5'(band + $urandom_range(0, 3));
            end else if (pick < 72) begin
                op = fsgs_pkg::OP_PASS;
            end else if (pick < 99) begin
                op = fsgs_pkg::OP_READ;
                if ($urandom_range(1) != 0) r = 5'($urandom_range(GRID_SIDE - 8, GRID_SIDE - 1));
            end else begin
                op = fsgs_pkg::OP_CLEAR;
            end
            queue_cmd(op, r, c);
        end
    endtask

    // ---------------------------------------------------------------------------------
    // driver: takes jobs from the list, holds start / cfg valid until the handshake
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic              took_cmd;
        logic              took_seed;
        logic              nxt_start;
        logic              nxt_cfg_valid;
        logic              idle_allowed;
        fsgs_pkg::t_cmd    nxt_cmd;
        logic [15:0]       nxt_seed;
        t_grid_job         head;
        fsgs_pkg::t_result pred;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            foreach (sand_grid[r]) sand_grid[r] = '0;
            choice_lfsr = fsgs_pkg::SEED_RESET;
        end else begin
            took_cmd      = start && !busy;
            took_seed     = i_cfg_valid && o_cfg_ready;
            nxt_start     = start && !took_cmd;
            nxt_cfg_valid = i_cfg_valid && !took_seed;
            nxt_cmd       = i_cmd;
            nxt_seed      = i_cfg_data;
            // prediction is made in acceptance order, seed writes included
            if (took_cmd) begin
                pred              = predict_sand_step(i_cmd);
                predicted_results = {predicted_results, pred};
                words_sent++;
            end
            if (took_seed) begin
                load_seed(i_cfg_data);
            end
            // a calm window in the middle of the run with no sender gaps at all
            idle_allowed = !(words_sent >= CALM_FIRST && words_sent < CALM_LAST);
            if (!nxt_start && !nxt_cfg_valid && grid_jobs.size() != 0) begin
                head = grid_jobs[0];
                case (head.kind)
                    JOB_CMD: begin
                        if (!(idle_allowed && $urandom_range(99) < 33)) begin
                            nxt_start = 1'b1;
                            nxt_cmd   = head.cmd;
                            void'(grid_jobs.pop_front());
                        end
                    end
                    JOB_SEED: begin
                        // seed only goes in once every result is back
                        if (predicted_results.size() == 0 && !took_cmd) begin
                            nxt_cfg_valid = 1'b1;
                            nxt_seed      = head.seed;
                            void'(grid_jobs.pop_front());
                        end
                    end
                    default: begin
                        // sender pause until the block has drained
                        if (predicted_results.size() == 0 && !took_cmd) begin
                            void'(grid_jobs.pop_front());
                        end
                    end
                endcase
            end
            start       <= nxt_start;
            i_cmd       <= nxt_cmd;
            i_cfg_valid <= nxt_cfg_valid;
            i_cfg_data  <= nxt_seed;
        end
    end

    // ---------------------------------------------------------------------------------
    // monitor: results cannot be held off, so o_valid is looked at every cycle
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        fsgs_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            words_seen++;
            if (predicted_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("result word %0d with nothing pending: occupied=%0b moved=%0d",
                             words_seen, o_result.occupied, o_result.moved_grains);
                end
            end else begin
                want = predicted_results.pop_front();
                if (o_result.occupied !== want.occupied ||
                    o_result.moved_grains !== want.moved_grains) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("result word %0d: occupied exp %0b got %0b, moved exp %0d got %0d",
                                 words_seen, want.occupied, o_result.occupied,
                                 want.moved_grains, o_result.moved_grains);
                    end
                end
            end
        end
    end

    // watchdog: any handshake or result resets the quiet count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------------------------
    initial begin
        // directed part, reset seed in force
        queue_cmd(fsgs_pkg::OP_READ,  5'd5,  5'd7);     // empty grid reads 0
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd31, 5'd0);     // floor, left edge
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd30, 5'd0);     // left wall counts as full: must go right
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd31, 5'd31);
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd30, 5'd31);    // right wall counts as full: must go left
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd31, 5'd16);
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd30, 5'd16);    // both diagonals free: lfsr decides
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd30, 5'd16);    // place on a full cell
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd0,  5'd0);     // top corner, falls straight
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd31, 5'd10);
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd30, 5'd9);
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd30, 5'd11);
        queue_cmd(fsgs_pkg::OP_PLACE, 5'd29, 5'd10);    // falls into the gap its neighbors leave
        queue_cmd(fsgs_pkg::OP_PASS,  5'd31, 5'd1);
        queue_cmd(fsgs_pkg::OP_READ,  5'd31, 5'd30);
        queue_cmd(fsgs_pkg::OP_READ,  5'd29, 5'd10);
        queue_cmd(fsgs_pkg::OP_PASS,  5'd1,  5'd0);
        queue_cmd(fsgs_pkg::OP_READ,  5'd2,  5'd0);
        queue_cmd(fsgs_pkg::OP_CLEAR, 5'd31, 5'd0);
        queue_cmd(fsgs_pkg::OP_READ,  5'd31, 5'd0);
        queue_cmd(fsgs_pkg::OP_PASS,  5'd31, 5'd31);    // empty grid moves nothing

        // random phases; the first two run under the fallback seed, the rest each under a new seed
        queue_seed(16'h0000);                 // zero seed falls back to the fixed value
        queue_random(300);
        queue_settle();
        queue_random(250);
        queue_seed(16'hFFFF);
        queue_random(300);
        queue_seed(16'h0001);
        queue_random(300);
        queue_seed(16'($urandom_range(1, 65535)));
        queue_random(400);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_sent != cmds_queued || grid_jobs.size() != 0 ||
               predicted_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (predicted_results.size() != 0) begin
            fail_count += predicted_results.size();
            $display("%0d result words never arrived", predicted_results.size());
        end
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
